// ===== rtl/core/prbs_energy_dispersal_top_defines.svh =====
// Assertion macros used by the scrambler RTL
`ifndef PRBS_ENERGY_DISPERSAL_TOP_DEFINES_SVH
`define PRBS_ENERGY_DISPERSAL_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PED_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scrambler assertion failed");

// next-cycle implication, disabled in reset
`define PED_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scrambler assertion failed");

`endif

// ===== rtl/core/ped_pkg.sv =====
// Package: widths, register indexes and the byte-wide LFSR step
package ped_pkg;

    localparam int LFSR_W        = 15;
    localparam int BYTE_W        = 8;
    localparam int PPF_W         = 8;
    localparam int CFG_DATA_W    = 15;
    localparam int PACKET_BYTES_DEFAULT = 204;

    localparam logic [LFSR_W-1:0] SEED_RESET = 15'd169;
    localparam logic [PPF_W-1:0]  PPF_RESET  = 8'd204;
    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h47;

    typedef enum logic [0:0] {
        REG_PRBS_SEED         = 1'b0,
        REG_PACKETS_PER_FRAME = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [LFSR_W-1:0] lfsr;
        logic [BYTE_W-1:0] prbs;
    } lfsr_step_t;

    // eight shifts of 1 + x^14 + x^15, first feedback bit lands in the MSB
    function automatic lfsr_step_t prbs_clock_byte(input logic [LFSR_W-1:0] s);
        lfsr_step_t        r;
        logic [LFSR_W-1:0] st;
        logic [BYTE_W-1:0] acc;
        logic              fb;
        st  = s;
        acc = '0;
        for (int k = 0; k < BYTE_W; k++)
        begin
            fb  = st[13] ^ st[14];
            st  = {st[LFSR_W-2:0], fb};
            acc = {acc[BYTE_W-2:0], fb};
        end
        r.lfsr = st;
        r.prbs = acc;
        return r;
    endfunction

endpackage

// ===== rtl/core/ped_in_if.sv =====
// Input byte channel
interface ped_in_if
    import ped_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

// ===== rtl/core/ped_out_if.sv =====
// Output byte channel with packet status
interface ped_out_if
    import ped_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              sync_error;
    logic              packet_end;

    modport source (output valid, output out_byte, output sync_error, output packet_end,
                    input ready);
    modport sink   (input valid, input out_byte, input sync_error, input packet_end,
                    output ready);
endinterface

// ===== rtl/core/ped_cfg_if.sv =====
// Configuration write channel
interface ped_cfg_if
    import ped_pkg::*;
;
    logic                  valid;
    logic                  ready;
    cfg_index_t            index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/prbs_energy_dispersal_top.sv =====
// Energy-dispersal scrambler: byte-serial PRBS XOR of fixed-length packets but the last byte
//
//  channel  dir  payload                              transfer when
//  in_ch    in   data_byte[7:0]                       valid & ready
//  out_ch   out  out_byte[7:0], sync_error, packet_end valid & ready
//  cfg      in   index (seed / packets per frame), data[14:0]  valid & ready (ready always 1)
//
// One byte per cycle unless out_ch stalls; each byte passes the input register, then the result register.
// The eight LFSR shifts per byte are one combinational step between the two.
// A stalled output holds the result register; the input register fills, then in_ch.ready drops.
// Reset: seed 169, packets per frame 204, LFSR 169, packet and byte counters 0.
`include "prbs_energy_dispersal_top_defines.svh"

module prbs_energy_dispersal_top
    import ped_pkg::*;
#(
    parameter int PACKET_BYTES = PACKET_BYTES_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    ped_in_if.sink    in_ch,
    ped_out_if.source out_ch,
    ped_cfg_if.sink   cfg
);

    localparam int POS_W = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(PACKET_BYTES - 1);

    logic [LFSR_W-1:0] seed_reg;
    logic [PPF_W-1:0]  ppf_reg;
    logic [LFSR_W-1:0] lfsr_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [PPF_W-1:0]  pkt_reg;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_data_reg;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              sync_error_reg;
    logic              packet_end_reg;

    logic              advance;
    logic              last;
    logic              frame_start;
    logic [LFSR_W-1:0] lfsr_start;
    lfsr_step_t        step;
    logic [PPF_W:0]    pkt_inc;
    logic [LFSR_W-1:0] lfsr_next;
    logic [POS_W-1:0]  pos_next;
    logic [PPF_W-1:0]  pkt_next;

    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;
    assign cfg.ready   = 1'b1;

    assign frame_start = (pos_reg == '0) && (pkt_reg == '0);
    assign lfsr_start  = frame_start ? seed_reg : lfsr_reg;
    assign step        = prbs_clock_byte(lfsr_start);
    assign last        = (pos_reg >= POS_LAST);
    assign pkt_inc     = {1'b0, pkt_reg} + (PPF_W+1)'(1);

    always_comb
    begin
        lfsr_next = step.lfsr;
        if (last)
        begin
            pos_next = '0;
            pkt_next = (pkt_inc >= {1'b0, ppf_reg}) ? '0 : pkt_inc[PPF_W-1:0];
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
            pkt_next = pkt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg       <= SEED_RESET;
            ppf_reg        <= PPF_RESET;
            lfsr_reg       <= SEED_RESET;
            pos_reg        <= '0;
            pkt_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_PRBS_SEED:         seed_reg <= cfg.data;
                    REG_PACKETS_PER_FRAME: ppf_reg  <= cfg.data[PPF_W-1:0];
                    default:               ;
                endcase
            end

            if (in_ch.ready)
                s1_valid_reg <= in_ch.valid;

            if (advance)
            begin
                lfsr_reg <= lfsr_next;
                pos_reg  <= pos_next;
                pkt_reg  <= pkt_next;
            end

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
            s1_data_reg <= in_ch.data_byte;
        if (advance)
        begin
            out_byte_reg   <= last ? s1_data_reg : (s1_data_reg ^ step.prbs);
            sync_error_reg <= last && (s1_data_reg != SYNC_BYTE);
            packet_end_reg <= last;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_byte   = out_byte_reg;
    assign out_ch.sync_error = sync_error_reg;
    assign out_ch.packet_end = packet_end_reg;

    `PED_ASSERT_NEXT(a_adv_fills_out, advance, out_valid_reg)
    `PED_ASSERT_NEXT(a_last_wraps_pos, advance && last, (pos_reg == '0) && packet_end_reg)
    `PED_ASSERT_NEXT(a_last_passes_byte, advance && last, out_byte_reg == $past(s1_data_reg))
    `PED_ASSERT_SAME(a_no_overrun, in_ch.valid && in_ch.ready, !s1_valid_reg || advance)
    `PED_ASSERT_SAME(a_sync_err_on_end, out_valid_reg && sync_error_reg, packet_end_reg)

endmodule
